// ----- rtl/core/pal_pkg.sv -----
// shared types and constants for the positional array list
package pal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_INSERT = 3'd4,
        OP_READ   = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_MISS   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_INSERT = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic [CMP_W-1:0]   pos;
        logic [CMP_W-1:0]   count;
        logic signed [31:0] value;
    } t_cell_ctrl;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [POS_W-1:0]   position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         found_index;
        logic signed [31:0] read_value;
        logic [4:0]         element_count;
    } t_out_item;

endpackage

// ----- rtl/core/pal_in_if.sv -----
// request channel: opcode, position and value
interface pal_in_if;
    import pal_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/pal_out_if.sv -----
// result channel: status, index, read data and count
interface pal_out_if;
    import pal_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/pal_cell.sv -----
// one list slot: holds an element, shifts to or from its neighbors, compares
module pal_cell (
    input  logic                      i_clk,
    input  logic [pal_pkg::IDX_W-1:0] i_index,
    input  pal_pkg::t_cell_ctrl       i_ctrl,
    input  logic signed [31:0]        i_left,
    input  logic signed [31:0]        i_right,
    output logic signed [31:0]        o_data,
    output logic                      o_match
);
    import pal_pkg::*;

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic [CMP_W-1:0]   k;
    logic [CMP_W-1:0]   k_next;

    assign k      = CMP_W'(i_index);
    assign k_next = k + CMP_W'(1);

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.cmd)
            CMD_APPEND: begin
                if (k == i_ctrl.count) n_data = i_ctrl.value;
            end
            CMD_DELETE: begin
                if (k >= i_ctrl.pos && k_next < i_ctrl.count) n_data = i_right;
            end
            CMD_INSERT: begin
                if (k == i_ctrl.pos) begin
                    n_data = i_ctrl.value;
                end else if (k > i_ctrl.pos && k <= i_ctrl.count) begin
                    n_data = i_left;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    // only slots inside the list take part in a search
    assign o_match = (r_data == i_ctrl.value) && (k < i_ctrl.count);
endmodule

// ----- rtl/core/positional_array_list.sv -----
// Positional array list: ordered list of signed 32-bit words held in a row of cells.
// i_in carries opcode, position and value; o_out returns one result per request
// with status, found index, read value and the element count after the request.
// Both channels use valid/ready; a transfer happens when both are high.
// For every request the cells shift, write and compare in
// parallel, and the result is registered, so it appears on o_out the cycle after
// the input transfer. Throughput is one request per cycle while o_out is taken.
// The result register is the only buffer: when the receiver stalls, i_in.ready
// drops until the waiting result is transferred, and it rises again in the same
// cycle that the result leaves, so no cycle is lost.
// Reset clears the element count and the output valid; slot contents are not
// cleared, only slots below the count are ever read.
// Search reports the lowest matching index; a position at or beyond the count
// is reported as invalid, and append or insert into a full list reports full.
module positional_array_list (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pal_in_if.sink    i_in,
    pal_out_if.source o_out
);
    import pal_pkg::*;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic               accept;
    logic [CMP_W-1:0]   pos_w;
    logic [CMP_W-1:0]   cnt_w;
    logic               bad_pos;
    logic               full;
    t_cell_ctrl         ctrl;
    logic signed [31:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] match;
    logic               hit;
    logic [IDX_W-1:0]   hit_index;
    logic signed [31:0] rd_data;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign pos_w   = CMP_W'(i_in.payload.position);
    assign cnt_w   = CMP_W'(r_count);
    assign bad_pos = pos_w >= cnt_w;
    assign full    = r_count == CNT_W'(CAPACITY);

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] left;
        logic signed [31:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[g+1];
        end
        pal_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctrl  (ctrl),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g]),
            .o_match (match[g])
        );
    end

    // lowest matching slot wins
    always_comb begin
        hit       = 1'b0;
        hit_index = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (match[k]) begin
                hit       = 1'b1;
                hit_index = IDX_W'(k);
            end
        end
    end

    assign rd_data = cell_data[IDX_W'(i_in.payload.position)];

    always_comb begin
        ctrl.cmd   = CMD_HOLD;
        ctrl.pos   = pos_w;
        ctrl.count = cnt_w;
        ctrl.value = i_in.payload.value;
        n_count    = r_count;
        n_out      = '0;
        unique case (i_in.payload.opcode)
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_APPEND: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    ctrl.cmd = CMD_APPEND;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (bad_pos) begin
                    n_out.status = ST_BADPOS;
                end else begin
                    ctrl.cmd = CMD_DELETE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_SEARCH: begin
                if (hit) begin
                    n_out.found_index = 4'(hit_index);
                end else begin
                    n_out.status = ST_MISS;
                end
            end
            OP_INSERT: begin
                if (bad_pos) begin
                    n_out.status = ST_BADPOS;
                end else if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    ctrl.cmd = CMD_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_READ: begin
                if (bad_pos) begin
                    n_out.status = ST_BADPOS;
                end else begin
                    n_out.read_value = rd_data;
                end
            end
            default: begin
                n_out.status = ST_BADPOS;
            end
        endcase
        n_out.element_count = 5'(n_count);
        if (!accept) begin
            ctrl.cmd = CMD_HOLD;
            n_count  = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;
endmodule

// ----- tb/list_check_pkg.sv -----
// scoreboard for the positional array list: shadow list and result comparison
package list_check_pkg;
    import pal_pkg::*;

    class list_scoreboard;
        logic signed [31:0] shadow_words [CAPACITY];
        int                 shadow_len;
        t_out_item          due_results [$];
        int unsigned        error_count;
        int unsigned        op_hits [6];
        int unsigned        status_hits [4];

        function new();
            shadow_len  = 0;
            error_count = 0;
            foreach (shadow_words[i]) shadow_words[i] = '0;
            foreach (op_hits[i]) op_hits[i] = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        // apply one accepted request to the shadow list and queue its outcome
        function void note_request(t_in_item req);
            t_out_item res;
            int        k;
            res        = '0;
            res.status = ST_OK;
            case (req.opcode)
                OP_CLEAR: begin
                    shadow_len = 0;
                end
                OP_APPEND: begin
                    if (shadow_len >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        shadow_words[shadow_len] = req.value;
                        shadow_len++;
                    end
                end
                OP_DELETE: begin
                    if (req.position >= shadow_len) begin
                        res.status = ST_BADPOS;
                    end else begin
                        for (k = req.position + 1; k < shadow_len; k++)
                            shadow_words[k-1] = shadow_words[k];
                        shadow_len--;
                    end
                end
                OP_SEARCH: begin
                    res.status = ST_MISS;
                    // lowest matching index wins
                    for (k = 0; k < shadow_len && res.status == ST_MISS; k++) begin
                        if (shadow_words[k] == req.value) begin
                            res.status      = ST_OK;
                            res.found_index = k[3:0];
                        end
                    end
                end
                OP_INSERT: begin
                    // bad position takes priority over full
                    if (req.position >= shadow_len) begin
                        res.status = ST_BADPOS;
                    end else if (shadow_len >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        for (k = shadow_len; k > req.position; k--)
                            shadow_words[k] = shadow_words[k-1];
                        shadow_words[req.position] = req.value;
                        shadow_len++;
                    end
                end
                OP_READ: begin
                    if (req.position >= shadow_len)
                        res.status = ST_BADPOS;
                    else
                        res.read_value = shadow_words[req.position];
                end
                default: begin
                    res.status = ST_BADPOS;
                end
            endcase
            res.element_count = shadow_len[4:0];
            if (req.opcode < 6)
                op_hits[req.opcode]++;
            status_hits[res.status]++;
            due_results.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                $error("result with no request outstanding: status %0d count %0d",
                       got.status, got.element_count);
                error_count++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                error_count++;
            end
            if (got.found_index !== want.found_index) begin
                $error("found_index: expected %0d, actual %0d",
                       want.found_index, got.found_index);
                error_count++;
            end
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, actual %0d",
                       want.read_value, got.read_value);
                error_count++;
            end
            if (got.element_count !== want.element_count) begin
                $error("element_count: expected %0d, actual %0d",
                       want.element_count, got.element_count);
                error_count++;
            end
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
// top-level testbench for the positional array list
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;
    import list_check_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pal_in_if  req_ch ();
    pal_out_if res_ch ();

    positional_array_list uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    list_scoreboard sb;
    int             cycle_count = 0;
    int             sent_count  = 0;
    bit             calm        = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.payload);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.payload);
        end
    end

    // result side: random back-pressure plus one long hold-off to fill the block
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && sent_count >= HOLD_AT) begin
                res_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else begin
                res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input t_opcode op, input logic [3:0] pos,
                                input logic signed [31:0] val);
        t_in_item req;
        req.opcode   = op;
        req.position = pos;
        req.value    = val;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= req;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    // grow phases push the list toward full, the others drain it
    task automatic random_request(input bit grow);
        int unsigned        roll;
        int                 len;
        t_opcode            op;
        logic [3:0]         pos;
        logic signed [31:0] val;
        len  = sb.shadow_len;
        roll = $urandom_range(99);
        if (roll < (grow ? 2 : 4))        op = OP_CLEAR;
        else if (roll < (grow ? 34 : 14)) op = OP_APPEND;
        else if (roll < (grow ? 50 : 24)) op = OP_INSERT;
        else if (roll < 62)               op = OP_DELETE;
        else if (roll < 81)               op = OP_SEARCH;
        else                              op = OP_READ;

        if (len > 0 && $urandom_range(3) != 0)
            pos = 4'($urandom_range(len - 1));
        else
            pos = 4'($urandom_range(15));

        roll = $urandom_range(9);
        if (roll < 5)
            val = $urandom;
        else if (roll < 8)
            val = $signed($urandom_range(7)) - 4;
        else begin
            case ($urandom_range(3))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = -1;
                default: val = 0;
            endcase
        end
        // searches mostly look for a value that is present
        if (op == OP_SEARCH && len > 0 && $urandom_range(9) < 6)
            val = sb.shadow_words[$urandom_range(len - 1)];
        send_request(op, pos, val);
    endtask

    initial begin
        int n;
        sb             = new();
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list
        send_request(OP_READ,   4'd0, 0);
        send_request(OP_DELETE, 4'd0, 0);
        send_request(OP_INSERT, 4'd0, 32'sd99);
        send_request(OP_SEARCH, 4'd0, 0);
        // build -1, min, 0, max
        send_request(OP_APPEND, 4'd0, 32'sh8000_0000);
        send_request(OP_APPEND, 4'd0, 32'sh7fff_ffff);
        send_request(OP_INSERT, 4'd0, -1);
        send_request(OP_INSERT, 4'd2, 0);
        send_request(OP_SEARCH, 4'd0, 32'sh7fff_ffff);
        send_request(OP_READ,   4'd3, 0);
        send_request(OP_READ,   4'd4, 0);
        for (n = 4; n < CAPACITY; n++)
            send_request(OP_APPEND, 4'd0, $urandom);
        // full list
        send_request(OP_APPEND, 4'd0, 32'sd7);
        send_request(OP_INSERT, 4'd15, 32'sd7);
        send_request(OP_READ,   4'd15, 0);
        send_request(OP_DELETE, 4'd15, 0);
        send_request(OP_DELETE, 4'd0, 0);
        send_request(OP_CLEAR,  4'd15, -1);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 300 && n < 450);
            random_request((n / 100) % 2 == 0);
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d clear, %0d append, %0d delete, %0d search, %0d insert, %0d read",
                 sent_count, sb.op_hits[OP_CLEAR], sb.op_hits[OP_APPEND],
                 sb.op_hits[OP_DELETE], sb.op_hits[OP_SEARCH],
                 sb.op_hits[OP_INSERT], sb.op_hits[OP_READ]);
        $display("outcomes: %0d ok, %0d bad position, %0d full, %0d not found; %0d mismatches",
                 sb.status_hits[ST_OK], sb.status_hits[ST_BADPOS],
                 sb.status_hits[ST_FULL], sb.status_hits[ST_MISS], sb.error_count);
        if (sb.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.due_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pal_pkg.sv
rtl/core/pal_in_if.sv
rtl/core/pal_out_if.sv
rtl/core/pal_cell.sv
rtl/core/positional_array_list.sv
tb/list_check_pkg.sv
tb/tb_top.sv
